// ===== sv/zsbf_pkg.sv =====
// shared types and constants for the stored-block zlib framer
// no dependencies; used by every module of the block by scoped names
`default_nettype none
package zsbf_pkg;

	localparam int LENGTH_BITS = 24;
	localparam int QDEPTH      = 4;
	localparam int QPTR_BITS   = $clog2(QDEPTH);

	localparam logic [7:0]  ZHDR_CMF   = 8'h78;
	localparam logic [7:0]  ZHDR_FLG   = 8'h01;
	localparam logic [15:0] STORED_MAX = 16'hffff;
	localparam logic [16:0] ADLER_MOD  = 17'd65521;

	// one classified input byte, everything the back end needs to frame it
	typedef struct packed {
		logic [7:0]  data;
		logic        zhdr;
		logic        blkhdr;
		logic        final_blk;
		logic [15:0] blk_len;
		logic        last;
		logic [15:0] sum_high;
		logic [15:0] sum_low;
	} cmd_t;

	typedef struct packed {
		logic                 full;
		logic                 empty;
		logic [QPTR_BITS:0]   count;
	} q_status_t;

	typedef enum logic [3:0] {
		ST_CMF,
		ST_FLG,
		ST_FINAL,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_NLEN_LO,
		ST_NLEN_HI,
		ST_DATA,
		ST_CHK3,
		ST_CHK2,
		ST_CHK1,
		ST_CHK0
	} step_t;

endpackage
`default_nettype wire

// ===== sv/zsbf_front.sv =====
// front end: takes raw bytes, tracks frame and block counters and adler-32,
// and builds one framing command per byte; depends on zsbf_pkg
`default_nettype none
module zsbf_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                total_length_we,
	input  wire logic [23:0]                         total_length,
	input  wire logic                                take,
	input  wire logic [7:0]                          data_byte,
	output zsbf_pkg::cmd_t                           cmd
);

	logic [zsbf_pkg::LENGTH_BITS-1:0] total_q;
	logic [zsbf_pkg::LENGTH_BITS-1:0] bytes_taken_q;
	logic [16:0]                      block_left_q;
	logic [15:0]                      sum_low_q;
	logic [15:0]                      sum_high_q;

	logic [zsbf_pkg::LENGTH_BITS-1:0] total;
	logic [zsbf_pkg::LENGTH_BITS-1:0] rem;
	logic [zsbf_pkg::LENGTH_BITS:0]   taken_inc;
	logic                             fits;
	logic [15:0]                      blk;
	logic [16:0]                      low_sum;
	logic [16:0]                      high_sum;
	logic [15:0]                      low_next;
	logic [15:0]                      high_next;
	logic [16:0]                      left_next;
	logic                             last;

	always_comb begin
		total = (total_q == '0) ? zsbf_pkg::LENGTH_BITS'(1) : total_q;
		rem = (bytes_taken_q < total) ? (total - bytes_taken_q)
			: zsbf_pkg::LENGTH_BITS'(1);
		fits = (rem[zsbf_pkg::LENGTH_BITS-1:16] == '0);
		blk = fits ? rem[15:0] : zsbf_pkg::STORED_MAX;
		left_next = (block_left_q == '0) ? ({1'b0, blk} - 17'd1)
			: (block_left_q - 17'd1);

		// adler-32 by conditional subtraction, both sums stay below the modulus
		low_sum = {1'b0, sum_low_q} + {9'd0, data_byte};
		low_next = (low_sum >= zsbf_pkg::ADLER_MOD)
			? 16'(low_sum - zsbf_pkg::ADLER_MOD) : low_sum[15:0];
		high_sum = {1'b0, sum_high_q} + {1'b0, low_next};
		high_next = (high_sum >= zsbf_pkg::ADLER_MOD)
			? 16'(high_sum - zsbf_pkg::ADLER_MOD) : high_sum[15:0];

		taken_inc = {1'b0, bytes_taken_q} + 1'b1;
		last = (taken_inc >= {1'b0, total});

		cmd.data      = data_byte;
		cmd.zhdr      = (bytes_taken_q == '0);
		cmd.blkhdr    = (block_left_q == '0);
		cmd.final_blk = fits;
		cmd.blk_len   = blk;
		cmd.last      = last;
		cmd.sum_high  = high_next;
		cmd.sum_low   = low_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= zsbf_pkg::LENGTH_BITS'(1);
		end else if (total_length_we) begin
			total_q <= zsbf_pkg::LENGTH_BITS'(total_length);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_taken_q <= '0;
			block_left_q  <= '0;
			sum_low_q     <= 16'd1;
			sum_high_q    <= '0;
		end else if (take) begin
			if (last) begin
				// frame closes: counters and sums back to their start
				bytes_taken_q <= '0;
				block_left_q  <= '0;
				sum_low_q     <= 16'd1;
				sum_high_q    <= '0;
			end else begin
				bytes_taken_q <= taken_inc[zsbf_pkg::LENGTH_BITS-1:0];
				block_left_q  <= left_next;
				sum_low_q     <= low_next;
				sum_high_q    <= high_next;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/zsbf_queue.sv =====
// short command queue between front and back end, flop storage
// depends on zsbf_pkg for the command type and depth
`default_nettype none
module zsbf_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire zsbf_pkg::cmd_t  wr_cmd,
	input  wire logic            pop,
	output zsbf_pkg::cmd_t       head,
	output zsbf_pkg::q_status_t  status
);

	zsbf_pkg::cmd_t                      mem_q [zsbf_pkg::QDEPTH];
	logic [zsbf_pkg::QPTR_BITS-1:0]      wr_ptr_q;
	logic [zsbf_pkg::QPTR_BITS-1:0]      rd_ptr_q;
	logic [zsbf_pkg::QPTR_BITS:0]        count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == (zsbf_pkg::QPTR_BITS+1)'(zsbf_pkg::QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/zsbf_back.sv =====
// back end: walks each queued command byte by byte into the output register
// depends on zsbf_pkg for the command type and step encoding
`default_nettype none
module zsbf_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire zsbf_pkg::cmd_t  head,
	input  wire logic            q_empty,
	output logic                 pop,
	output logic                 dst_valid,
	input  wire logic            dst_stall,
	output logic [7:0]           out_byte,
	output logic                 run_last,
	output logic                 stream_done
);

	zsbf_pkg::step_t step_q;
	logic            started_q;
	zsbf_pkg::step_t cur_step;
	zsbf_pkg::step_t next_step;
	zsbf_pkg::step_t first_step;
	logic            at_end;
	logic            fire;
	logic            load;
	logic [7:0]      byte_sel;
	logic [15:0]     nlen;

	logic            dst_valid_q;
	logic [7:0]      out_byte_q;
	logic            run_last_q;
	logic            stream_done_q;

	assign nlen = ~head.blk_len;
	assign load = !dst_valid_q || !dst_stall;
	assign fire = load && !q_empty;

	always_comb begin
		if (head.zhdr) begin
			first_step = zsbf_pkg::ST_CMF;
		end else if (head.blkhdr) begin
			first_step = zsbf_pkg::ST_FINAL;
		end else begin
			first_step = zsbf_pkg::ST_DATA;
		end
		cur_step = started_q ? step_q : first_step;
	end

	// next step
	always_comb begin
		next_step = cur_step;
		at_end    = 1'b0;
		unique case (cur_step) inside
			zsbf_pkg::ST_FLG: begin
				next_step = head.blkhdr ? zsbf_pkg::ST_FINAL : zsbf_pkg::ST_DATA;
			end
			zsbf_pkg::ST_DATA: begin
				next_step = zsbf_pkg::ST_CHK3;
				at_end    = !head.last;
			end
			zsbf_pkg::ST_CHK0: begin
				at_end = 1'b1;
			end
			zsbf_pkg::ST_CMF, zsbf_pkg::ST_FINAL, zsbf_pkg::ST_LEN_LO,
			zsbf_pkg::ST_LEN_HI, zsbf_pkg::ST_NLEN_LO, zsbf_pkg::ST_NLEN_HI,
			zsbf_pkg::ST_CHK3, zsbf_pkg::ST_CHK2, zsbf_pkg::ST_CHK1: begin
				next_step = zsbf_pkg::step_t'(cur_step + 4'd1);
			end
			default: begin
				next_step = zsbf_pkg::ST_CMF;
				at_end    = 1'b1;
			end
		endcase
	end

	// byte for the current step
	always_comb begin
		unique case (cur_step)
			zsbf_pkg::ST_CMF:     byte_sel = zsbf_pkg::ZHDR_CMF;
			zsbf_pkg::ST_FLG:     byte_sel = zsbf_pkg::ZHDR_FLG;
			zsbf_pkg::ST_FINAL:   byte_sel = {7'd0, head.final_blk};
			zsbf_pkg::ST_LEN_LO:  byte_sel = head.blk_len[7:0];
			zsbf_pkg::ST_LEN_HI:  byte_sel = head.blk_len[15:8];
			zsbf_pkg::ST_NLEN_LO: byte_sel = nlen[7:0];
			zsbf_pkg::ST_NLEN_HI: byte_sel = nlen[15:8];
			zsbf_pkg::ST_DATA:    byte_sel = head.data;
			zsbf_pkg::ST_CHK3:    byte_sel = head.sum_high[15:8];
			zsbf_pkg::ST_CHK2:    byte_sel = head.sum_high[7:0];
			zsbf_pkg::ST_CHK1:    byte_sel = head.sum_low[15:8];
			zsbf_pkg::ST_CHK0:    byte_sel = head.sum_low[7:0];
			default:              byte_sel = head.data;
		endcase
	end

	assign pop = fire && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= zsbf_pkg::ST_CMF;
			started_q <= 1'b0;
		end else if (fire) begin
			step_q    <= next_step;
			started_q <= !at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (load) begin
			dst_valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q    <= byte_sel;
			run_last_q    <= at_end;
			stream_done_q <= (cur_step == zsbf_pkg::ST_CHK0);
		end
	end

	assign dst_valid   = dst_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = run_last_q;
	assign stream_done = stream_done_q;

endmodule
`default_nettype wire

// ===== sv/zlib_stored_block_framer_top.sv =====
// top level of the stored-block zlib framer with adler-32 trailer
// depends on zsbf_pkg, zsbf_front, zsbf_queue, zsbf_back
//
//  channel  | handshake              | payload
//  src      | src_valid / src_stall  | data_byte
//  dst      | dst_valid / dst_stall  | out_byte, run_last, stream_done
//  config   | total_length_we        | total_length
//
// a raw byte is taken every cycle while the four-entry command queue has room
// each byte leaves as 1 to 12 output beats, one beat per cycle from the back end
// unless dst_stall holds it, so the sustained byte rate is set by the output side:
// 1 beat per byte in a block, 6 with a block header, 2 more at frame start, 4 at end
// reset clears counters, sums, the queue and dst_valid; total_length resets to 1
// dst_stall holds output register and back end; the queue absorbs up to four bytes
`default_nettype none
module zlib_stored_block_framer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        total_length_we,
	input  wire logic [23:0] total_length,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic [7:0]  data_byte,
	output logic             dst_valid,
	input  wire logic        dst_stall,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             stream_done
);

	zsbf_pkg::cmd_t      new_cmd;
	zsbf_pkg::cmd_t      head;
	zsbf_pkg::q_status_t q_status;
	logic                push;
	logic                pop;

	assign src_stall = q_status.full;
	assign push      = src_valid && !q_status.full;

	zsbf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.total_length_we (total_length_we),
		.total_length    (total_length),
		.take            (push),
		.data_byte       (data_byte),
		.cmd             (new_cmd)
	);

	zsbf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (new_cmd),
		.pop    (pop),
		.head   (head),
		.status (q_status)
	);

	zsbf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_status.empty),
		.pop         (pop),
		.dst_valid   (dst_valid),
		.dst_stall   (dst_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.stream_done (stream_done)
	);

`ifndef ASSERT_OFF
	// checksum close is always the last beat of its byte
	a_done_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && stream_done |-> run_last)
		else $error("stream_done without run_last");

	// back end never retires a command from an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

	// queue occupancy grows by one on a push without a pop
	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> q_status.count == $past(q_status.count) + 1'b1)
		else $error("queue count did not grow on push");
`endif

endmodule
`default_nettype wire
